/* sv/kbd_pkg.sv */
// Shared types, constants and scancode tables for the keyboard character FIFO.
`default_nettype none

package kbd_pkg;

	localparam int KBD_FIFO_DEPTH = 256;
	localparam int CHAR_W         = 7;
	localparam int CODE_W         = 8;
	localparam int RES_W          = 10;
	localparam int M_TDATA_W      = 16;
	localparam int TABLE_LEN      = 58;

	// tuser codes on the slave side
	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// set-1 codes with a side effect
	localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [CODE_W-1:0] SC_CAPS_MAKE    = 8'h3A;

	typedef struct packed {
		logic              has_char;
		logic [CHAR_W-1:0] ch;
	} kbd_char_t;

	// result word, lowest bit first: read_char, read_valid, chars_waiting, overflow_drop
	typedef struct packed {
		logic              overflow_drop;
		logic              chars_waiting;
		logic              read_valid;
		logic [CHAR_W-1:0] read_char;
	} kbd_res_t;

	localparam logic [CHAR_W-1:0] LOWER_MAP [TABLE_LEN] = '{
		7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	localparam logic [CHAR_W-1:0] UPPER_MAP [TABLE_LEN] = '{
		7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
		7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
		7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
		7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
		7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	function automatic logic [CHAR_W-1:0] kbd_lookup(input logic [CODE_W-1:0] code,
		input logic upper);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (code < CODE_W'(TABLE_LEN)) begin
			ch = upper ? UPPER_MAP[code[5:0]] : LOWER_MAP[code[5:0]];
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

/* sv/kbd_decode.sv */
// Shift and caps-lock tracking plus scancode to ASCII translation.
`default_nettype none

module kbd_decode (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          ev_en,
	input  wire logic [kbd_pkg::CODE_W-1:0]    scancode,
	output kbd_pkg::kbd_char_t                 dec
);
	import kbd_pkg::*;

	logic shift_q;
	logic caps_q;
	logic shift_nx;
	logic caps_nx;

	always_comb begin
		shift_nx = shift_q;
		if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE) begin
			shift_nx = 1'b1;
		end else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK) begin
			shift_nx = 1'b0;
		end
		caps_nx = caps_q ^ (scancode == SC_CAPS_MAKE);
	end

	// lookup uses the flags as updated by this very code
	always_comb begin
		dec.ch       = kbd_lookup(scancode, shift_nx ^ caps_nx);
		dec.has_char = (dec.ch != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (ev_en) begin
			shift_q <= shift_nx;
			caps_q  <= caps_nx;
		end
	end

endmodule

`default_nettype wire

/* sv/keyboard_scancode_to_ascii_fifo.sv */
// Accepted transactions are registered in s1, then written to the result queue.
// Throughput: one transaction per cycle while s_tready is high. The character store has
// one write and one read port, both used in the accept cycle, with read data registered.
// A 3-entry result queue decouples m_tready from s_tready.
// Reset: pointers, key flags and result queue cleared; character store is not cleared.
`default_nettype none

module keyboard_scancode_to_ascii_fifo #(
	parameter int FIFO_DEPTH = kbd_pkg::KBD_FIFO_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [kbd_pkg::CODE_W-1:0]       s_tdata,  // scancode
	input  wire logic                             s_tuser,  // cmd
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// read_char[6:0], read_valid[7], chars_waiting[8], overflow_drop[9], zero pad
	output      logic [kbd_pkg::M_TDATA_W-1:0]    m_tdata
);
	import kbd_pkg::*;

	localparam int PTR_W    = $clog2(FIFO_DEPTH);
	localparam int OQ_DEPTH = 3;
	localparam int OQ_W     = $clog2(OQ_DEPTH);
	localparam int OQC_W    = $clog2(OQ_DEPTH + 2);

	logic [CHAR_W-1:0] mem [FIFO_DEPTH];

	logic [PTR_W-1:0] wp_q, rp_q, wp_inc, rp_inc, wp_nx, rp_nx;
	logic             s_acc, ev, rd, full, empty, push, drop, pop;
	kbd_char_t        dec;

	logic              valid_s1, pop_s1, waiting_s1, drop_s1;
	logic [CHAR_W-1:0] rd_data_s1;

	kbd_res_t          res_s1;
	kbd_res_t          oq_q [OQ_DEPTH];
	logic [OQ_W-1:0]   oq_wr_q, oq_rd_q;
	logic [OQC_W-1:0]  oq_cnt_q;
	logic              m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign ev    = s_acc && (s_tuser == CMD_EVENT);
	assign rd    = s_acc && (s_tuser == CMD_READ);

	kbd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_en    (ev),
		.scancode (s_tdata),
		.dec      (dec)
	);

	assign wp_inc = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign full   = (wp_inc == rp_q);
	assign empty  = (wp_q == rp_q);
	assign push   = ev && dec.has_char && !full;
	assign drop   = ev && dec.has_char && full;
	assign pop    = rd && !empty;
	assign wp_nx  = push ? wp_inc : wp_q;
	assign rp_nx  = pop ? rp_inc : rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_nx;
			rp_q <= rp_nx;
		end
	end

	// a popped slot was written in an earlier cycle, so read and write never collide
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= dec.ch;
		end
		if (pop) begin
			rd_data_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pop_s1     <= pop;
			drop_s1    <= drop;
			waiting_s1 <= (wp_nx != rp_nx);
		end
	end

	always_comb begin
		res_s1.read_char     = pop_s1 ? rd_data_s1 : '0;
		res_s1.read_valid    = pop_s1;
		res_s1.chars_waiting = waiting_s1;
		res_s1.overflow_drop = drop_s1;
	end

	// result queue; admission counts the transaction still in s1
	assign s_tready = (oq_cnt_q + OQC_W'(valid_s1)) < OQC_W'(OQ_DEPTH);
	assign m_tvalid = (oq_cnt_q != '0);
	assign m_acc    = m_tvalid && m_tready;
	assign m_tdata  = {(M_TDATA_W - RES_W)'(0), oq_q[oq_rd_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				oq_wr_q <= (oq_wr_q == OQ_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			end
			if (m_acc) begin
				oq_rd_q <= (oq_rd_q == OQ_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + OQC_W'(valid_s1) - OQC_W'(m_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wr_q] <= res_s1;
		end
	end

endmodule

`default_nettype wire

/* sv/kbd_chk.sv */
// Port-level checker for the keyboard character FIFO, bound to the top level.
`default_nettype none

module kbd_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [kbd_pkg::CODE_W-1:0]    s_tdata,
	input wire logic                          s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [kbd_pkg::M_TDATA_W-1:0] m_tdata
);
	import kbd_pkg::*;

	kbd_res_t res;
	assign res = m_tdata[RES_W-1:0];

	// only non-zero characters are ever stored
	a_pop_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.read_valid |-> res.read_char != '0)
		else $error("popped character is zero");

	a_nopop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.read_valid |-> res.read_char == '0)
		else $error("character present without a pop");

	a_drop_not_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.read_valid && res.overflow_drop))
		else $error("drop and pop in one transaction");

	// a drop means the store was full, so it still holds characters
	a_drop_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.overflow_drop |-> res.chars_waiting)
		else $error("drop reported with empty store");

	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("master transaction changed while stalled");

endmodule

bind keyboard_scancode_to_ascii_fifo kbd_chk u_kbd_chk (.*);

`default_nettype wire
